// ===== hdl/scfla_pkg.sv =====
// ----------------------------------------------------------------------------
// scfla_pkg
// Shared types and constants of the size-class free-list allocator.
// ----------------------------------------------------------------------------
package scfla_pkg;

    localparam int OFF_W   = 21;    // byte offsets and sizes on the ports
    localparam int SIZEU_W = 18;    // rounded request size in 16-byte units
    localparam int STORE_W = 17;    // stored block size in units

    localparam logic [1:0] CLS_64    = 2'd0;
    localparam logic [1:0] CLS_512   = 2'd1;
    localparam logic [1:0] CLS_1024  = 2'd2;
    localparam logic [1:0] CLS_LARGE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] REG_HEAP_LIMIT = 3'd0;
    localparam logic [OFF_W-1:0] HEAP_LIMIT_RESET = 21'd1048576;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_BUMP,
        S_WALK,
        S_CHECK,
        S_PUSH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FAIL,
        CMD_POP_RD,
        CMD_POP_WR,
        CMD_BUMP,
        CMD_WALK_INIT,
        CMD_WALK_RD,
        CMD_UNLINK,
        CMD_ADVANCE,
        CMD_FREE_RD,
        CMD_PUSH
    } t_cmd;

    typedef struct packed {
        logic op;
        logic fixed_cls;
        logic head_valid;
        logic free_ok;
        logic walk_ok;
        logic fit;
    } t_status;

endpackage

// ===== hdl/scfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// scfla_ctrl
// Sequencer: steps one request through pop, walk, bump or push.
// ----------------------------------------------------------------------------
module scfla_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  scfla_pkg::t_status i_status,
    output scfla_pkg::t_cmd    o_cmd,
    output logic               o_busy
);

    scfla_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scfla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = scfla_pkg::CMD_NONE;
        unique case (r_state)
            scfla_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd   = scfla_pkg::CMD_LOAD;
                    n_state = scfla_pkg::S_DISPATCH;
                end
            end
            scfla_pkg::S_DISPATCH: begin
                if (i_status.op == scfla_pkg::OP_FREE) begin
                    if (i_status.free_ok) begin
                        o_cmd   = scfla_pkg::CMD_FREE_RD;
                        n_state = scfla_pkg::S_PUSH;
                    end else begin
                        o_cmd   = scfla_pkg::CMD_FAIL;
                        n_state = scfla_pkg::S_IDLE;
                    end
                end else if (i_status.fixed_cls) begin
                    if (i_status.head_valid) begin
                        o_cmd   = scfla_pkg::CMD_POP_RD;
                        n_state = scfla_pkg::S_POP;
                    end else begin
                        n_state = scfla_pkg::S_BUMP;
                    end
                end else begin
                    o_cmd   = scfla_pkg::CMD_WALK_INIT;
                    n_state = scfla_pkg::S_WALK;
                end
            end
            scfla_pkg::S_POP: begin
                o_cmd   = scfla_pkg::CMD_POP_WR;
                n_state = scfla_pkg::S_IDLE;
            end
            scfla_pkg::S_BUMP: begin
                o_cmd   = scfla_pkg::CMD_BUMP;
                n_state = scfla_pkg::S_IDLE;
            end
            scfla_pkg::S_WALK: begin
                if (i_status.walk_ok) begin
                    o_cmd   = scfla_pkg::CMD_WALK_RD;
                    n_state = scfla_pkg::S_CHECK;
                end else begin
                    n_state = scfla_pkg::S_BUMP;
                end
            end
            scfla_pkg::S_CHECK: begin
                if (i_status.fit) begin
                    o_cmd   = scfla_pkg::CMD_UNLINK;
                    n_state = scfla_pkg::S_IDLE;
                end else begin
                    o_cmd   = scfla_pkg::CMD_ADVANCE;
                    n_state = scfla_pkg::S_WALK;
                end
            end
            scfla_pkg::S_PUSH: begin
                o_cmd   = scfla_pkg::CMD_PUSH;
                n_state = scfla_pkg::S_IDLE;
            end
            default: begin
                n_state = scfla_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != scfla_pkg::S_IDLE);

endmodule

// ===== hdl/scfla_dp.sv =====
// ----------------------------------------------------------------------------
// scfla_dp
// Datapath: list heads, bump pointer, link and size stores, result word.
// ----------------------------------------------------------------------------
module scfla_dp #(
    parameter int HEAP_UNITS = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scfla_pkg::t_cmd             i_cmd,
    input  logic                        i_operation,
    input  logic [scfla_pkg::OFF_W-1:0] i_request_size,
    input  logic [scfla_pkg::OFF_W-1:0] i_block_offset,
    input  logic                        i_cfg_we,
    input  logic [scfla_pkg::OFF_W-1:0] i_cfg_data,
    output logic [scfla_pkg::OFF_W-1:0] o_limit,
    output scfla_pkg::t_status          o_status,
    output logic                        o_result_valid,
    output logic [scfla_pkg::OFF_W-1:0] o_result_offset,
    output logic                        o_granted
);

    localparam int UW = $clog2(HEAP_UNITS);
    localparam int LW = UW + 1;
    localparam logic [31:0] HEAP_BYTES = 32'(HEAP_UNITS) * 32'd16;
    localparam logic [31:0] UNITS32    = 32'(HEAP_UNITS);

    logic [LW-1:0]      r_link_mem [HEAP_UNITS];
    logic [scfla_pkg::STORE_W-1:0] r_size_mem [HEAP_UNITS];

    logic [LW-1:0]                   r_heads [4];
    logic [scfla_pkg::OFF_W-1:0]     r_bump;
    logic [scfla_pkg::OFF_W-1:0]     r_limit;
    logic                            r_op;
    logic [scfla_pkg::SIZEU_W-1:0]   r_size_u;
    logic [1:0]                      r_cls;
    logic [scfla_pkg::OFF_W-1:0]     r_off;
    logic [UW-1:0]                   r_unit;
    logic [UW-1:0]                   r_prev;
    logic                            r_has_prev;
    logic [LW-1:0]                   r_link;
    logic [UW:0]                     r_steps;
    logic [LW-1:0]                   r_link_rd;
    logic [scfla_pkg::STORE_W-1:0]   r_size_rd;
    logic                            r_res_valid;
    logic [scfla_pkg::OFF_W-1:0]     r_res_off;
    logic                            r_res_grant;

    logic [scfla_pkg::OFF_W:0]       sum_req;
    logic [scfla_pkg::SIZEU_W-1:0]   units_req;
    logic [scfla_pkg::SIZEU_W-1:0]   size_u_cls;
    logic [1:0]                      cls_req;
    logic [31:0]                     lim;
    logic [31:0]                     bump32;
    logic [31:0]                     bump_end;
    logic [UW-1:0]                   bump_unit;
    logic                            bump_ok;
    logic [31:0]                     hdr32;
    logic [UW-1:0]                   free_unit;
    logic [LW-1:0]                   head_sel;
    logic [LW-1:0]                   head_m1;
    logic [LW-1:0]                   link_m1;
    logic [1:0]                      push_cls;
    logic [31:0]                     data32;

    // request rounding: header plus round-up to 16 bytes, in units
    always_comb begin
        sum_req   = {1'b0, i_request_size} + 22'd31;
        units_req = sum_req[scfla_pkg::OFF_W:4];
        if (units_req <= 18'd4) begin
            cls_req    = scfla_pkg::CLS_64;
            size_u_cls = 18'd4;
        end else if (units_req <= 18'd32) begin
            cls_req    = scfla_pkg::CLS_512;
            size_u_cls = 18'd32;
        end else if (units_req <= 18'd64) begin
            cls_req    = scfla_pkg::CLS_1024;
            size_u_cls = 18'd64;
        end else begin
            cls_req    = scfla_pkg::CLS_LARGE;
            size_u_cls = units_req;
        end
    end

    always_comb begin
        lim       = (HEAP_BYTES < 32'(r_limit)) ? HEAP_BYTES : 32'(r_limit);
        bump32    = 32'(r_bump);
        bump_end  = bump32 + (32'(r_size_u) << 4);
        bump_unit = bump32[UW+3:4];
        bump_ok   = (bump_end < lim) && ((bump32 >> 4) < UNITS32);
        hdr32     = 32'(r_off) - 32'd16;
        free_unit = hdr32[UW+3:4];
        head_sel  = r_heads[r_cls];
        head_m1   = head_sel - LW'(1);
        link_m1   = r_link - LW'(1);
        data32    = (32'(r_unit) << 4) + 32'd16;
        if (r_size_rd <= 17'd4) begin
            push_cls = scfla_pkg::CLS_64;
        end else if (r_size_rd <= 17'd32) begin
            push_cls = scfla_pkg::CLS_512;
        end else if (r_size_rd <= 17'd64) begin
            push_cls = scfla_pkg::CLS_1024;
        end else begin
            push_cls = scfla_pkg::CLS_LARGE;
        end
    end

    always_comb begin
        o_status.op         = r_op;
        o_status.fixed_cls  = (r_cls != scfla_pkg::CLS_LARGE);
        o_status.head_valid = (head_sel != '0) && (32'(head_sel) <= UNITS32);
        o_status.free_ok    = (r_off >= 21'd16) && (r_off[3:0] == 4'd0)
                              && (hdr32 < bump32) && (hdr32 < HEAP_BYTES)
                              && ((hdr32 >> 4) < UNITS32);
        o_status.walk_ok    = (r_link != '0) && (32'(r_link) <= UNITS32)
                              && (32'(r_steps) < UNITS32);
        o_status.fit        = ({1'b0, r_size_rd} >= r_size_u);
    end

    // link and size stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            scfla_pkg::CMD_POP_RD: r_link_rd <= r_link_mem[head_m1[UW-1:0]];
            scfla_pkg::CMD_WALK_RD: begin
                r_link_rd <= r_link_mem[link_m1[UW-1:0]];
                r_size_rd <= r_size_mem[link_m1[UW-1:0]];
            end
            scfla_pkg::CMD_FREE_RD: r_size_rd <= r_size_mem[free_unit];
            scfla_pkg::CMD_BUMP: begin
                if (bump_ok) begin
                    r_size_mem[bump_unit] <= r_size_u[scfla_pkg::STORE_W-1:0];
                end
            end
            scfla_pkg::CMD_UNLINK: begin
                if (r_has_prev) begin
                    r_link_mem[r_prev] <= r_link_rd;
                end
            end
            scfla_pkg::CMD_PUSH: r_link_mem[r_unit] <= r_heads[push_cls];
            default: ;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            scfla_pkg::CMD_LOAD: begin
                r_op     <= i_operation;
                r_size_u <= size_u_cls;
                r_cls    <= cls_req;
                r_off    <= i_block_offset;
            end
            scfla_pkg::CMD_POP_RD:    r_unit <= head_m1[UW-1:0];
            scfla_pkg::CMD_WALK_INIT: begin
                r_link     <= r_heads[scfla_pkg::CLS_LARGE];
                r_steps    <= '0;
                r_has_prev <= 1'b0;
            end
            scfla_pkg::CMD_WALK_RD:   r_unit <= link_m1[UW-1:0];
            scfla_pkg::CMD_ADVANCE: begin
                r_prev     <= r_unit;
                r_has_prev <= 1'b1;
                r_link     <= r_link_rd;
                r_steps    <= r_steps + (UW+1)'(1);
            end
            scfla_pkg::CMD_FREE_RD:   r_unit <= free_unit;
            scfla_pkg::CMD_BUMP:      r_unit <= bump_unit;
            default: ;
        endcase
    end

    // control state: heads, bump pointer, limit, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_heads[i] <= '0;
            end
            r_bump      <= '0;
            r_limit     <= scfla_pkg::HEAP_LIMIT_RESET;
            r_res_valid <= 1'b0;
            r_res_off   <= '0;
            r_res_grant <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            unique case (i_cmd)
                scfla_pkg::CMD_FAIL: begin
                    r_res_valid <= 1'b1;
                    r_res_off   <= '0;
                    r_res_grant <= 1'b0;
                end
                scfla_pkg::CMD_POP_WR: begin
                    r_heads[r_cls] <= r_link_rd;
                    r_res_valid    <= 1'b1;
                    r_res_off      <= data32[scfla_pkg::OFF_W-1:0];
                    r_res_grant    <= 1'b1;
                end
                scfla_pkg::CMD_BUMP: begin
                    r_res_valid <= 1'b1;
                    r_res_grant <= bump_ok;
                    if (bump_ok) begin
                        r_bump    <= bump_end[scfla_pkg::OFF_W-1:0];
                        r_res_off <= 21'((32'(bump_unit) << 4) + 32'd16);
                    end else begin
                        r_res_off <= '0;
                    end
                end
                scfla_pkg::CMD_UNLINK: begin
                    if (!r_has_prev) begin
                        r_heads[scfla_pkg::CLS_LARGE] <= r_link_rd;
                    end
                    r_res_valid <= 1'b1;
                    r_res_off   <= data32[scfla_pkg::OFF_W-1:0];
                    r_res_grant <= 1'b1;
                end
                scfla_pkg::CMD_PUSH: begin
                    r_heads[push_cls] <= LW'(r_unit) + LW'(1);
                    r_res_valid       <= 1'b1;
                    r_res_off         <= '0;
                    r_res_grant       <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_limit         = r_limit;
    assign o_result_valid  = r_res_valid;
    assign o_result_offset = r_res_off;
    assign o_granted       = r_res_grant;

endmodule

// ===== hdl/size_class_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// size_class_free_list_allocator
// Segregated free-list heap allocator: fixed-class LIFO lists, first-fit
// large list, bump allocation from the heap start.
// ----------------------------------------------------------------------------
// Path from accept to result strobe: a rejected free ends at dispatch, a
// free goes on to push, a small request to pop or bump; a large request
// walks the list node by node (one link/size store read per node)
// to unlink the first fit, else bumps; busy drops in the strobe cycle.
// One request at a time; next word can be accepted in the strobe cycle.
// Synchronous active-low reset empties all lists, clears the bump pointer
// and sets the heap limit to 1 MiB; the stores are not cleared.
module size_class_free_list_allocator #(
    parameter int HEAP_UNITS = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [scfla_pkg::OFF_W-1:0] i_request_size,
    input  logic [scfla_pkg::OFF_W-1:0] i_block_offset,
    output logic                        o_result_valid,
    output logic [scfla_pkg::OFF_W-1:0] o_result_offset,
    output logic                        o_granted,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    scfla_pkg::t_cmd             cmd;
    scfla_pkg::t_status          status;
    logic                        cfg_we;
    logic [scfla_pkg::OFF_W-1:0] limit;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == scfla_pkg::REG_HEAP_LIMIT);
    assign prdata = (paddr == scfla_pkg::REG_HEAP_LIMIT) ? 32'(limit) : 32'd0;

    scfla_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    scfla_dp #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_operation),
        .i_request_size  (i_request_size),
        .i_block_offset  (i_block_offset),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (pwdata[scfla_pkg::OFF_W-1:0]),
        .o_limit         (limit),
        .o_status        (status),
        .o_result_valid  (o_result_valid),
        .o_result_offset (o_result_offset),
        .o_granted       (o_granted)
    );

endmodule

// ===== hdl/scfla_checker.sv =====
// ----------------------------------------------------------------------------
// scfla_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module scfla_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic [20:0] o_result_offset,
    input logic        o_granted
);

    // an accepted word keeps the block busy until its result
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result only closes a request that was in flight
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) && !busy))
        else $error("result without a request in flight");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_offset_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_offset != 21'd0)) |->
        (o_granted && (o_result_offset[3:0] == 4'd0)))
        else $error("bad nonzero result offset");

endmodule

bind size_class_free_list_allocator scfla_checker u_scfla_checker (.*);

// ===== tb/scfla_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfla_scoreboard
// Watches the request, result and register ports of the allocator, keeps
// its own copy of the heap lists, predicts each result and compares it.
// ----------------------------------------------------------------------------
module scfla_scoreboard (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic                        i_operation,
    input  logic [scfla_pkg::OFF_W-1:0] i_request_size,
    input  logic [scfla_pkg::OFF_W-1:0] i_block_offset,
    input  logic                        i_result_valid,
    input  logic [scfla_pkg::OFF_W-1:0] i_result_offset,
    input  logic                        i_granted,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [2:0]                  i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int UNITS      = 65536;
    localparam int HEAP_BYTES = UNITS * 16;

    typedef struct {
        logic [scfla_pkg::OFF_W-1:0] offset;
        logic                        granted;
    } t_alloc_word;

    t_alloc_word                 grant_q[$];
    logic [scfla_pkg::OFF_W-1:0] limit_bytes;
    int unsigned                 bump_bytes;
    int unsigned                 heads[4];
    int unsigned                 next_link[UNITS];
    int unsigned                 size_units[UNITS];
    int                          fail_count = 0;
    int                          pending = 0;

    function automatic logic [1:0] class_of(input int unsigned bytes);
        if (bytes <= 64) return scfla_pkg::CLS_64;
        if (bytes <= 512) return scfla_pkg::CLS_512;
        if (bytes <= 1024) return scfla_pkg::CLS_1024;
        return scfla_pkg::CLS_LARGE;
    endfunction

    task automatic run_alloc(input int unsigned req, output t_alloc_word w);
        int unsigned size;
        int unsigned unit;
        int unsigned link;
        int unsigned prev;
        int unsigned steps;
        int unsigned lim;
        int unsigned data_off;
        logic [1:0]  cls;
        bit          found;
        bit          has_prev;
        size = ((req + 31) >> 4) << 4;
        cls = class_of(size);
        found = 0;
        unit = 0;
        case (cls)
            scfla_pkg::CLS_64:   size = 64;
            scfla_pkg::CLS_512:  size = 512;
            scfla_pkg::CLS_1024: size = 1024;
            default:  ;
        endcase
        if (cls != scfla_pkg::CLS_LARGE) begin
            if (heads[cls] != 0 && heads[cls] <= UNITS) begin
                unit = heads[cls] - 1;
                heads[cls] = next_link[unit];
                found = 1;
            end
        end else begin
            link = heads[scfla_pkg::CLS_LARGE];
            steps = 0;
            has_prev = 0;
            prev = 0;
            while (!found && steps < UNITS && link != 0 && link <= UNITS) begin
                if (size_units[link-1] * 16 >= size) begin
                    if (has_prev) next_link[prev] = next_link[link-1];
                    else heads[scfla_pkg::CLS_LARGE] = next_link[link-1];
                    unit = link - 1;
                    found = 1;
                end else begin
                    prev = link - 1;
                    has_prev = 1;
                    link = next_link[link-1];
                    steps++;
                end
            end
        end
        w.offset = '0;
        w.granted = 1'b0;
        if (!found) begin
            lim = (limit_bytes < HEAP_BYTES) ? 32'(limit_bytes) : HEAP_BYTES;
            if (bump_bytes + size >= lim || bump_bytes / 16 >= UNITS) return;
            unit = bump_bytes / 16;
            size_units[unit] = size / 16;
            bump_bytes += size;
        end
        data_off = unit * 16 + 16;
        w.offset = data_off[scfla_pkg::OFF_W-1:0];
        w.granted = 1'b1;
    endtask

    function automatic logic run_free(input int unsigned off);
        int unsigned hdr;
        logic [1:0]  cls;
        if (off < 16 || off[3:0] != 0) return 1'b0;
        hdr = off - 16;
        if (hdr >= bump_bytes || hdr >= HEAP_BYTES) return 1'b0;
        cls = class_of(size_units[hdr/16] * 16);
        next_link[hdr/16] = heads[cls];
        heads[cls] = hdr / 16 + 1;
        return 1'b1;
    endfunction

    assign o_pending    = pending;
    assign o_fail_count = fail_count;

    always @(posedge i_clk) begin
        t_alloc_word w;
        t_alloc_word exp_w;
        if (!i_rst_n) begin
            limit_bytes = scfla_pkg::HEAP_LIMIT_RESET;
            bump_bytes = 0;
            heads = '{default: 0};
            grant_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == scfla_pkg::REG_HEAP_LIMIT)
                limit_bytes = i_pwdata[scfla_pkg::OFF_W-1:0];
            if (i_start && !i_busy) begin
                if (i_operation == scfla_pkg::OP_ALLOC) begin
                    run_alloc(32'(i_request_size), w);
                end else begin
                    w.offset = '0;
                    w.granted = run_free(32'(i_block_offset));
                end
                grant_q.push_back(w);
            end
            if (i_result_valid) begin
                if (grant_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected word offset=%0d granted=%0b",
                                 $realtime, i_result_offset, i_granted);
                end else begin
                    exp_w = grant_q.pop_front();
                    if (i_result_offset !== exp_w.offset || i_granted !== exp_w.granted) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch offset exp %0d got %0d, granted exp %0b got %0b",
                                     $realtime, exp_w.offset, i_result_offset,
                                     exp_w.granted, i_granted);
                    end
                end
            end
        end
        pending = grant_q.size();
    end

endmodule

// ===== tb/tb_size_class_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_free_list_allocator
// Drives allocate and free requests with random gaps over several heap
// limits; the scoreboard predicts every word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_size_class_free_list_allocator;

    localparam int CYCLE_LIMIT = 10000000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        i_operation = scfla_pkg::OP_ALLOC;
    logic [scfla_pkg::OFF_W-1:0] i_request_size = '0;
    logic [scfla_pkg::OFF_W-1:0] i_block_offset = '0;
    logic                        o_result_valid;
    logic [scfla_pkg::OFF_W-1:0] o_result_offset;
    logic                        o_granted;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [2:0]                  paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    int                          fail_count;
    int                          pending;
    int                          cycles = 0;
    int unsigned                 live_q[$];

    always #5 i_clk = ~i_clk;

    size_class_free_list_allocator u_top (.*);

    scfla_scoreboard u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_operation(i_operation), .i_request_size(i_request_size),
        .i_block_offset(i_block_offset), .i_result_valid(o_result_valid),
        .i_result_offset(o_result_offset), .i_granted(o_granted),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // granted allocations become candidates for later frees
    always @(posedge i_clk) begin
        cycles++;
        if (o_result_valid && o_result_offset != 0) live_q.push_back(32'(o_result_offset));
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic issue(input logic op, input int unsigned req, input int unsigned off);
        int unsigned gap;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        gap = (pick < 70) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_request_size <= req[scfla_pkg::OFF_W-1:0];
        i_block_offset <= off[scfla_pkg::OFF_W-1:0];
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(input int unsigned value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= scfla_pkg::REG_HEAP_LIMIT;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int unsigned random_size();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 62) return $urandom_range(0, 1008);
        if (pick < 94) return $urandom_range(1009, 16384);
        if (pick < 98) return $urandom_range(16385, 65536);
        return $urandom_range(65537, 2097151);
    endfunction

    task automatic random_item();
        int unsigned pick;
        int unsigned idx;
        int unsigned off;
        pick = $urandom_range(0, 99);
        if (pick < 55 || (pick < 90 && live_q.size() == 0)) begin
            issue(scfla_pkg::OP_ALLOC, random_size(), $urandom_range(0, 2097151));
        end else if (pick < 90) begin
            idx = $urandom_range(0, live_q.size() - 1);
            off = live_q[idx];
            live_q.delete(idx);
            issue(scfla_pkg::OP_FREE, $urandom_range(0, 2097151), off);
        end else begin
            case ($urandom_range(0, 3))
                0: off = 0;
                1: off = $urandom_range(1, 15);
                2: off = 1048592 + 16 * $urandom_range(0, 65535);
                default: off = (live_q.size() != 0) ?
                               live_q[0] + $urandom_range(1, 15) : 2097151;
            endcase
            issue(scfla_pkg::OP_FREE, $urandom_range(0, 2097151), off);
        end
    endtask

    initial begin
        int unsigned sizes[$];
        int unsigned limits[4];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: null and invalid frees, class boundaries, failing bumps
        issue(scfla_pkg::OP_FREE, 0, 0);
        issue(scfla_pkg::OP_FREE, 0, 16);
        sizes = '{0, 48, 49, 496, 497, 1008, 1009, 4000, 1048576, 2097151};
        foreach (sizes[i]) issue(scfla_pkg::OP_ALLOC, sizes[i], 0);
        issue(scfla_pkg::OP_FREE, 2097151, 24);
        issue(scfla_pkg::OP_FREE, 0, 2097136);
        issue(scfla_pkg::OP_FREE, 0, 2097151);
        drain();
        // free everything, then reuse: large first-fit gives the bigger freed block to 2000
        while (live_q.size() != 0) issue(scfla_pkg::OP_FREE, 0, live_q.pop_front());
        sizes = '{0, 496, 1008, 2000, 1009};
        foreach (sizes[i]) issue(scfla_pkg::OP_ALLOC, sizes[i], 0);

        limits = '{2097151, 0, $urandom_range(20000, 600000), 1048576};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            repeat (245) random_item();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/scfla_pkg.sv
hdl/scfla_ctrl.sv
hdl/scfla_dp.sv
hdl/size_class_free_list_allocator.sv
hdl/scfla_checker.sv
tb/scfla_checker.sv
tb/tb_size_class_free_list_allocator.sv
